>>> hdl/xxhash32_stream_hasher_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef XXHASH32_STREAM_HASHER_UNIT_MACROS_SVH
`define XXHASH32_STREAM_HASHER_UNIT_MACROS_SVH

// Next-cycle implication, disabled while reset is held.
`define XXH_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("xxh32 assertion failed");

// Reset check: the cycle after each edge with reset held must show post.
`define XXH_ASSERT_RESET(lbl, clk, rst_n, post) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (post)) \
        else $error("xxh32 assertion failed");

`endif

>>> hdl/xxh32_pkg.sv
// ----------------------------------------------------------------------------
// xxh32_pkg
// Shared constants and types of the xxHash32 stream hasher.
// ----------------------------------------------------------------------------
package xxh32_pkg;

    localparam logic [31:0] P1 = 32'd2654435761;
    localparam logic [31:0] P2 = 32'd2246822519;
    localparam logic [31:0] P3 = 32'd3266489917;
    localparam logic [31:0] P4 = 32'd668265263;
    localparam logic [31:0] P5 = 32'd374761393;

    localparam int QUEUE_DEPTH = 2;

    // One classified input beat as it travels through the queue.
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;   // clamped to 0..4
        logic        full_word;
        logic        first_word;
        logic        last_word;
        logic [31:0] seed_value;
        logic [31:0] message_length;
    } t_item;

endpackage

>>> hdl/xxh32_front.sv
// ----------------------------------------------------------------------------
// xxh32_front
// Accepts input beats, clamps the byte count, and queues them for the core.
// ----------------------------------------------------------------------------
module xxh32_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [31:0]      i_data_word,
    input  logic [2:0]       i_byte_count,
    input  logic             i_first_word,
    input  logic             i_last_word,
    input  logic [31:0]      i_seed_value,
    input  logic [31:0]      i_message_length,
    output logic             o_item_valid,
    output xxh32_pkg::t_item o_item,
    input  logic             i_item_pop
);

    xxh32_pkg::t_item r_queue [xxh32_pkg::QUEUE_DEPTH];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;
    xxh32_pkg::t_item w_new;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        w_new.data_word      = i_data_word;
        w_new.byte_count     = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        w_new.full_word      = (i_byte_count >= 3'd4);
        w_new.first_word     = i_first_word;
        w_new.last_word      = i_last_word;
        w_new.seed_value     = i_seed_value;
        w_new.message_length = i_message_length;
    end

    assign o_stall      = (r_count == 2'(xxh32_pkg::QUEUE_DEPTH));
    assign w_push       = i_valid && !o_stall;
    assign o_item_valid = (r_count != 2'd0);
    assign w_pop        = i_item_pop && o_item_valid;
    assign o_item       = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_new;
        end
    end

endmodule

>>> hdl/xxh32_core.sv
// ----------------------------------------------------------------------------
// xxh32_core
// Sequencer that mixes queued beats into the hash state over one multiplier.
// ----------------------------------------------------------------------------
module xxh32_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  xxh32_pkg::t_item i_item,
    output logic             o_item_pop,
    output logic             o_valid,
    output logic [31:0]      o_hash_value,
    input  logic             i_stall
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_DISP = 13'b0000000000010,
        S_LA   = 13'b0000000000100,
        S_LB   = 13'b0000000001000,
        S_WA   = 13'b0000000010000,
        S_WB   = 13'b0000000100000,
        S_BA   = 13'b0000001000000,
        S_BB   = 13'b0000010000000,
        S_M1   = 13'b0000100000000,
        S_M2   = 13'b0001000000000,
        S_END  = 13'b0010000000000,
        S_A1   = 13'b0100000000000,
        S_A2   = 13'b1000000000000
    } t_state;

    t_state           r_state, n_state;
    xxh32_pkg::t_item r_item;
    logic [31:0]      r_lane [4];
    logic [31:0]      r_hash;
    logic [31:0]      r_bytes;
    logic [31:0]      r_total;
    logic             r_stripe;
    logic [31:0]      r_tmp;
    logic [1:0]       r_bidx;
    logic             r_ret_bytes;
    logic             r_out_valid;
    logic [31:0]      r_out_hash;

    logic [31:0] w_mul_a, w_mul_b, w_prod;
    logic [1:0]  w_sel;
    logic [31:0] w_nb;
    logic [7:0]  w_byte;
    logic [31:0] w_sum;
    logic        w_out_free;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] d;
        d = {x, x} << r;
        return d[63:32];
    endfunction

    assign w_sel      = r_bytes[3:2];
    assign w_nb       = r_bytes + 32'd4;
    assign w_byte     = 8'(r_item.data_word >> {r_bidx, 3'b000});
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;

    // Shared multiplier: each state drives at most one product.
    always_comb begin
        w_mul_a = 32'd0;
        w_mul_b = 32'd0;
        w_sum   = 32'd0;
        unique case (r_state)
            S_LA: begin
                w_mul_a = r_item.data_word;
                w_mul_b = xxh32_pkg::P2;
            end
            S_LB: begin
                w_sum   = r_lane[w_sel] + r_tmp;
                w_mul_a = rotl(w_sum, 5'd13);
                w_mul_b = xxh32_pkg::P1;
            end
            S_WA: begin
                w_mul_a = r_item.data_word;
                w_mul_b = xxh32_pkg::P3;
            end
            S_WB: begin
                w_sum   = r_hash + r_tmp;
                w_mul_a = rotl(w_sum, 5'd17);
                w_mul_b = xxh32_pkg::P4;
            end
            S_BA: begin
                w_mul_a = {24'd0, w_byte};
                w_mul_b = xxh32_pkg::P5;
            end
            S_BB: begin
                w_sum   = r_hash + r_tmp;
                w_mul_a = rotl(w_sum, 5'd11);
                w_mul_b = xxh32_pkg::P1;
            end
            S_A1: begin
                w_mul_a = r_hash ^ (r_hash >> 15);
                w_mul_b = xxh32_pkg::P2;
            end
            S_A2: begin
                w_mul_a = r_tmp ^ (r_tmp >> 13);
                w_mul_b = xxh32_pkg::P3;
            end
            default: begin
                w_mul_a = 32'd0;
                w_mul_b = 32'd0;
            end
        endcase
        w_prod = w_mul_a * w_mul_b;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_item_valid) n_state = S_DISP;
            S_DISP: begin
                priority if (r_item.full_word && r_stripe) n_state = S_LA;
                else if (r_item.full_word)                 n_state = S_WA;
                else if (r_item.byte_count != 3'd0)        n_state = r_stripe ? S_M1 : S_BA;
                else                                       n_state = S_END;
            end
            S_LA: n_state = S_LB;
            S_LB: begin
                if ((w_nb[3:0] == 4'd0) && ((r_total - w_nb) < 32'd16)) begin
                    n_state = S_M1;
                end else begin
                    n_state = S_END;
                end
            end
            S_WA: n_state = S_WB;
            S_WB: n_state = S_END;
            S_BA: n_state = S_BB;
            S_BB: begin
                if (3'({1'b0, r_bidx} + 3'd1) == r_item.byte_count) begin
                    n_state = S_END;
                end else begin
                    n_state = S_BA;
                end
            end
            S_M1: n_state = S_M2;
            S_M2: n_state = r_ret_bytes ? S_BA : S_END;
            S_END: begin
                priority if (!r_item.last_word) n_state = S_IDLE;
                else if (r_stripe)              n_state = S_M1;
                else                            n_state = S_A1;
            end
            S_A1: n_state = S_A2;
            S_A2: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_stripe    <= 1'b0;
            r_hash      <= 32'd0;
            r_bytes     <= 32'd0;
            r_total     <= 32'd0;
            for (int i = 0; i < 4; i++) begin
                r_lane[i] <= 32'd0;
            end
        end else begin
            r_state <= n_state;
            // Raise on a finished hash, hold while stalled, drop once taken.
            r_out_valid <= ((r_state == S_A2) && w_out_free) || (r_out_valid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid && i_item.first_word) begin
                        r_total <= i_item.message_length;
                        r_bytes <= 32'd0;
                        if (i_item.message_length >= 32'd16) begin
                            r_lane[0] <= i_item.seed_value + xxh32_pkg::P1 + xxh32_pkg::P2;
                            r_lane[1] <= i_item.seed_value + xxh32_pkg::P2;
                            r_lane[2] <= i_item.seed_value;
                            r_lane[3] <= i_item.seed_value - xxh32_pkg::P1;
                            r_hash    <= 32'd0;
                            r_stripe  <= 1'b1;
                        end else begin
                            r_hash   <= i_item.seed_value + xxh32_pkg::P5
                                        + i_item.message_length;
                            r_stripe <= 1'b0;
                        end
                    end
                end
                S_LB: begin
                    r_lane[w_sel] <= w_prod;
                    r_bytes       <= w_nb;
                end
                S_WB: begin
                    r_hash  <= w_prod;
                    r_bytes <= w_nb;
                end
                S_BB: begin
                    r_hash <= w_prod;
                    if (3'({1'b0, r_bidx} + 3'd1) == r_item.byte_count) begin
                        r_bytes <= r_bytes + 32'(r_item.byte_count);
                    end
                end
                S_M2: begin
                    r_hash   <= r_tmp + rotl(r_lane[2], 5'd12) + rotl(r_lane[3], 5'd18);
                    r_stripe <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload side: no reset needed.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    r_item <= i_item;
                end
            end
            S_DISP: begin
                r_bidx      <= 2'd0;
                r_ret_bytes <= !r_item.full_word && (r_item.byte_count != 3'd0);
            end
            S_LA, S_WA, S_BA, S_A1: r_tmp <= w_prod;
            S_BB: r_bidx <= r_bidx + 2'd1;
            S_M1: r_tmp  <= rotl(r_lane[0], 5'd1) + rotl(r_lane[1], 5'd7) + r_total;
            S_END: r_ret_bytes <= 1'b0;
            S_A2: begin
                if (w_out_free) begin
                    r_out_hash <= w_prod ^ (w_prod >> 16);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hdl/xxhash32_stream_hasher_unit.sv
// Sequence: a full word passes pop, dispatch, two multiplies and wrap-up;
// each tail byte takes two multiplies, a lane merge its two sum steps (with
// wrap-up first when forced by the last word), the final avalanche two more multiplies.
// The core pops a new beat only from idle; the single shared 32x32 multiplier sets the pace.
// Reset: synchronous, active low; clears the queue, hash state and output valid.
// ----------------------------------------------------------------------------
// xxhash32_stream_hasher_unit
// Streaming xxHash32: a front queue accepts beats, a back sequencer hashes them.
// ----------------------------------------------------------------------------
module xxhash32_stream_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel: one message word per beat.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_message_length,
    // Output channel: one hash per message, on its last word.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    // Queue handoff between the front and the core.
    logic             w_item_valid;
    logic             w_item_pop;
    xxh32_pkg::t_item w_item;

    // Front: clamp the byte count, hold beats in a two-entry queue so the
    // input keeps flowing while the core is busy with multiplies.
    xxh32_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_data_word      (i_data_word),
        .i_byte_count     (i_byte_count),
        .i_first_word     (i_first_word),
        .i_last_word      (i_last_word),
        .i_seed_value     (i_seed_value),
        .i_message_length (i_message_length),
        .o_item_valid     (w_item_valid),
        .o_item           (w_item),
        .i_item_pop       (w_item_pop)
    );

    // Core: lane steps, word steps, byte steps and avalanche share one multiplier;
    // the merge uses adds and rotates only. Its output register lets the next beat start
    // while a finished hash waits to be taken.
    xxh32_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_valid      (o_out_valid),
        .o_hash_value (o_hash_value),
        .i_stall      (i_out_stall)
    );

endmodule

>>> hdl/xxh32_checker.sv
// ----------------------------------------------------------------------------
// xxh32_checker
// Port-level checks of the xxHash32 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`include "xxhash32_stream_hasher_unit_macros.svh"

module xxh32_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_hash_value
);

    `XXH_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `XXH_ASSERT_NEXT(a_out_hash_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_hash_value))
    `XXH_ASSERT_RESET(a_no_out_after_reset, i_clk, i_rst_n, !o_out_valid)
    `XXH_ASSERT_RESET(a_no_stall_after_reset, i_clk, i_rst_n, !o_in_stall)

endmodule

bind xxhash32_stream_hasher_unit xxh32_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hash_value (o_hash_value)
);
